[rtl/core/vas_pkg.sv]
// Shared types, cube tables and constants for the volume slicer.
`timescale 1ns / 1ps
package vas_pkg;
    localparam int V_W          = 16;
    localparam int D_W          = 20;
    localparam int IDX_W        = 8;
    localparam int SC_W         = 9;
    localparam int RM_W         = 10;
    localparam int Q_W          = 15;
    localparam int C_W          = 16;
    localparam int LANES        = 6;
    localparam int EDGES        = 12;
    localparam int FAN_LEN      = 12;
    localparam int MAX_SLICES_DEF = 256;
    localparam logic [C_W-1:0] FIX_ONE = 16'd32768;

    localparam logic [1:0] CLS_BELOW = 2'd0;
    localparam logic [1:0] CLS_DIV   = 2'd1;
    localparam logic [1:0] CLS_ABOVE = 2'd2;

    localparam logic REG_SLICE_COUNT  = 1'b0;
    localparam logic REG_RANGE_MARGIN = 1'b1;

    // bit0 = x, bit1 = y, bit2 = z
    localparam logic [2:0] CORNER_XYZ [8] = '{3'b000, 3'b001, 3'b011, 3'b010,
                                              3'b100, 3'b101, 3'b111, 3'b110};
    localparam logic [2:0] EDGE_S [12] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1,
                                           3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
    localparam logic [2:0] EDGE_T [12] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd4, 3'd5,
                                           3'd6, 3'd7, 3'd5, 3'd6, 3'd7, 3'd4};
    localparam logic [3:0] TRAV [8][12] = '{
        '{4'd0, 4'd1, 4'd5, 4'd6, 4'd4, 4'd8, 4'd11, 4'd9, 4'd3, 4'd7, 4'd2, 4'd10},
        '{4'd0, 4'd4, 4'd3, 4'd11, 4'd1, 4'd2, 4'd6, 4'd7, 4'd5, 4'd9, 4'd8, 4'd10},
        '{4'd1, 4'd5, 4'd0, 4'd8, 4'd2, 4'd3, 4'd7, 4'd4, 4'd6, 4'd10, 4'd9, 4'd11},
        '{4'd7, 4'd11, 4'd10, 4'd8, 4'd2, 4'd6, 4'd1, 4'd9, 4'd3, 4'd0, 4'd4, 4'd5},
        '{4'd8, 4'd5, 4'd9, 4'd1, 4'd11, 4'd10, 4'd7, 4'd6, 4'd4, 4'd3, 4'd0, 4'd2},
        '{4'd9, 4'd6, 4'd10, 4'd2, 4'd8, 4'd11, 4'd4, 4'd7, 4'd5, 4'd0, 4'd1, 4'd3},
        '{4'd9, 4'd8, 4'd5, 4'd4, 4'd6, 4'd1, 4'd2, 4'd0, 4'd10, 4'd7, 4'd11, 4'd3},
        '{4'd10, 4'd9, 4'd6, 4'd5, 4'd7, 4'd2, 4'd3, 4'd1, 4'd11, 4'd4, 4'd8, 4'd0}};
    localparam logic [2:0] FAN_ORDER [12] = '{3'd0, 3'd1, 3'd2, 3'd0, 3'd2, 3'd3,
                                              3'd0, 3'd3, 3'd4, 3'd0, 3'd4, 3'd5};

    typedef struct packed {
        logic [1:0] cls;
        logic [2:0] s;
        logic [1:0] axis;
        logic       neg;
    } t_lane;

    function automatic logic [1:0] edge_axis(input logic [3:0] e);
        logic [2:0] d;
        d = CORNER_XYZ[EDGE_S[e]] ^ CORNER_XYZ[EDGE_T[e]];
        priority if (d[0]) return 2'd0;
        else if (d[1])     return 2'd1;
        else               return 2'd2;
    endfunction

    // edge runs toward lower coordinate when its start sits at 1 on its axis
    function automatic logic edge_neg(input logic [3:0] e);
        logic [2:0] c;
        c = CORNER_XYZ[EDGE_S[e]];
        return c[edge_axis(e)];
    endfunction
endpackage

[rtl/core/vas_front.sv]
// Front stages: corner distances, range, edge numerators, hit tests and picks.
`timescale 1ns / 1ps
module vas_front #(
    parameter int MAX_SLICES = vas_pkg::MAX_SLICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [vas_pkg::V_W-1:0]    i_dir_x,
    input  logic signed [vas_pkg::V_W-1:0]    i_dir_y,
    input  logic signed [vas_pkg::V_W-1:0]    i_dir_z,
    input  logic [vas_pkg::IDX_W-1:0]         i_slice_index,
    input  logic [vas_pkg::SC_W-1:0]          i_slice_count,
    input  logic [vas_pkg::RM_W-1:0]          i_range_margin,
    output logic                              o_vld,
    output logic [$clog2(MAX_SLICES+1)+15:0]  o_rem [vas_pkg::LANES],
    output logic [$clog2(MAX_SLICES+1)+15:0]  o_den [vas_pkg::LANES],
    output vas_pkg::t_lane                    o_sb  [vas_pkg::LANES]
);
    import vas_pkg::*;
    localparam int NW    = $clog2(MAX_SLICES+1);
    localparam int NUM_W = NW + 23;
    localparam int DEN_W = NW + 16;

    // ---- stage A: latch item, corner dot products
    logic [NW-1:0]          n_eff;
    logic signed [D_W-1:0]  n_cd [8];
    logic signed [V_W-1:0]  v_in [3];
    logic                   r_a_vld, r_a_ok;
    logic signed [D_W-1:0]  r_a_cd [8];
    logic signed [V_W-1:0]  r_a_v [3];
    logic [IDX_W-1:0]       r_a_idx;
    logic [NW-1:0]          r_a_n;
    logic [RM_W-1:0]        r_a_mg;

    assign v_in[0] = i_dir_x;
    assign v_in[1] = i_dir_y;
    assign v_in[2] = i_dir_z;

    always_comb begin
        if (i_slice_count == '0) begin
            n_eff = NW'(1);
        end else if (int'(i_slice_count) > MAX_SLICES) begin
            n_eff = NW'(MAX_SLICES);
        end else begin
            n_eff = NW'(i_slice_count);
        end
        for (int c = 0; c < 8; c++) begin
            n_cd[c] = '0;
            for (int a = 0; a < 3; a++) begin
                if (CORNER_XYZ[c][a]) n_cd[c] = n_cd[c] + D_W'(v_in[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
        if (i_en) begin
            r_a_cd  <= n_cd;
            r_a_v   <= v_in;
            r_a_idx <= i_slice_index;
            r_a_n   <= n_eff;
            r_a_mg  <= i_range_margin;
            r_a_ok  <= int'(i_slice_index) < int'(n_eff);
        end
    end

    // ---- stage B: nearest / farthest corner, widened range
    logic signed [D_W-1:0]  n_dmin, n_dmax;
    logic [2:0]             n_far;
    logic                   r_b_vld, r_b_ok;
    logic signed [D_W-1:0]  r_b_dmin, r_b_rng;
    logic [2:0]             r_b_far;
    logic signed [D_W-1:0]  r_b_cd [8];
    logic signed [V_W-1:0]  r_b_v [3];
    logic [IDX_W-1:0]       r_b_idx;
    logic [NW-1:0]          r_b_n;

    always_comb begin
        n_dmin = '0;
        n_dmax = '0;
        n_far  = '0;
        for (int c = 1; c < 8; c++) begin
            if (r_a_cd[c] > n_dmax) begin
                n_dmax = r_a_cd[c];
                n_far  = 3'(c);
            end
            if (r_a_cd[c] < n_dmin) n_dmin = r_a_cd[c];
        end
        n_dmin = n_dmin - $signed(D_W'(r_a_mg));
        n_dmax = n_dmax + $signed(D_W'(r_a_mg));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
        if (i_en) begin
            r_b_dmin <= n_dmin;
            r_b_rng  <= n_dmax - n_dmin;
            r_b_far  <= n_far;
            r_b_cd   <= r_a_cd;
            r_b_v    <= r_a_v;
            r_b_idx  <= r_a_idx;
            r_b_n    <= r_a_n;
            r_b_ok   <= r_a_ok;
        end
    end

    // ---- stage C: per-corner offsets times N, i*R, |v|*N per axis
    logic signed [D_W+NW:0]   n_prod [8];
    logic [D_W+IDX_W-1:0]     n_bp;
    logic [V_W-1:0]           n_absv [3];
    logic                     r_c_vld, r_c_ok;
    logic signed [NUM_W-1:0]  r_c_a [8];
    logic signed [NUM_W-1:0]  r_c_b;
    logic [DEN_W-1:0]         r_c_den [3];
    logic [2:0]               r_c_vneg, r_c_vzero;
    logic [2:0]               r_c_far;

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            n_prod[c] = (r_b_dmin - r_b_cd[c]) * $signed({1'b0, r_b_n});
        end
        n_bp = r_b_idx * r_b_rng[D_W-1:0];
        for (int a = 0; a < 3; a++) begin
            n_absv[a] = r_b_v[a][V_W-1] ? V_W'(-r_b_v[a]) : V_W'(r_b_v[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
        if (i_en) begin
            for (int c = 0; c < 8; c++) r_c_a[c] <= NUM_W'(n_prod[c]);
            r_c_b <= $signed(NUM_W'(n_bp));
            for (int a = 0; a < 3; a++) begin
                r_c_den[a]   <= DEN_W'(n_absv[a] * r_b_n);
                r_c_vneg[a]  <= r_b_v[a][V_W-1];
                r_c_vzero[a] <= (r_b_v[a] == '0);
            end
            r_c_far <= r_b_far;
            r_c_ok  <= r_b_ok;
        end
    end

    // ---- stage D: numerator per traversal edge, hit tests
    logic signed [NUM_W-1:0]  n_num [EDGES];
    logic [EDGES-1:0]         n_hit, n_low;
    t_lane                    n_geo [EDGES];
    logic                     r_d_vld, r_d_ok;
    logic signed [NUM_W-1:0]  r_d_num [EDGES];
    logic [DEN_W-1:0]         r_d_den [EDGES];
    logic [EDGES-1:0]         r_d_hit, r_d_low;
    t_lane                    r_d_geo [EDGES];

    always_comb begin
        logic [3:0]              e;
        logic [1:0]              ax;
        logic signed [NUM_W-1:0] raw;
        for (int k = 0; k < EDGES; k++) begin
            e  = TRAV[r_c_far][k];
            ax = edge_axis(e);
            raw = r_c_a[EDGE_S[e]] + r_c_b;
            n_num[k] = (r_c_vneg[ax] ^ edge_neg(e)) ? -raw : raw;
            n_low[k] = r_c_vzero[ax] || (n_num[k] < 0);
            n_hit[k] = !n_low[k] && (n_num[k] < $signed(NUM_W'(r_c_den[ax])));
            n_geo[k].cls  = CLS_DIV;
            n_geo[k].s    = EDGE_S[e];
            n_geo[k].axis = ax;
            n_geo[k].neg  = edge_neg(e);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_d_vld <= r_c_vld;
        end
        if (i_en) begin
            r_d_num <= n_num;
            for (int k = 0; k < EDGES; k++) begin
                r_d_den[k] <= r_c_den[edge_axis(TRAV[r_c_far][k])];
            end
            r_d_hit <= n_hit;
            r_d_low <= n_low;
            r_d_geo <= n_geo;
            r_d_ok  <= r_c_ok;
        end
    end

    // ---- picks with fallbacks; result feeds the divider's first register
    logic [3:0] pk [LANES];
    logic [EDGES-1:0] h;
    assign h = r_d_hit;

    always_comb begin
        pk[0] = h[0] ? 4'd0 : h[1] ? 4'd1 : h[3] ? 4'd3 : 4'd0;
        pk[1] = h[2] ? 4'd2 : h[0] ? 4'd0 : h[1] ? 4'd1 : 4'd3;
        pk[2] = h[4] ? 4'd4 : h[5] ? 4'd5 : 4'd7;
        pk[3] = h[6] ? 4'd6 : h[4] ? 4'd4 : h[5] ? 4'd5 : 4'd7;
        pk[4] = h[8] ? 4'd8 : h[9] ? 4'd9 : 4'd11;
        pk[5] = h[10] ? 4'd10 : h[8] ? 4'd8 : h[9] ? 4'd9 : 4'd11;
        for (int j = 0; j < LANES; j++) begin
            o_rem[j] = DEN_W'(r_d_num[pk[j]]);
            o_den[j] = r_d_den[pk[j]];
            o_sb[j]  = r_d_geo[pk[j]];
            if (r_d_hit[pk[j]])      o_sb[j].cls = CLS_DIV;
            else if (r_d_low[pk[j]]) o_sb[j].cls = CLS_BELOW;
            else                     o_sb[j].cls = CLS_ABOVE;
        end
    end

    // plane misses and out-of-range slices drop out here
    assign o_vld = r_d_vld && r_d_ok && (h[0] || h[1] || h[3]);
endmodule

[rtl/core/vas_div.sv]
// Six-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module vas_div #(
    parameter int MAX_SLICES = vas_pkg::MAX_SLICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [$clog2(MAX_SLICES+1)+15:0]  i_rem [vas_pkg::LANES],
    input  logic [$clog2(MAX_SLICES+1)+15:0]  i_den [vas_pkg::LANES],
    input  vas_pkg::t_lane                    i_sb  [vas_pkg::LANES],
    output logic                              o_vld,
    output logic [vas_pkg::Q_W-1:0]           o_q   [vas_pkg::LANES],
    output vas_pkg::t_lane                    o_sb  [vas_pkg::LANES]
);
    import vas_pkg::*;
    localparam int DEN_W = $clog2(MAX_SLICES+1) + 16;

    logic              r_vld [Q_W];
    logic [DEN_W-1:0]  r_rem [Q_W][LANES];
    logic [DEN_W-1:0]  r_den [Q_W][LANES];
    logic [Q_W-1:0]    r_q   [Q_W][LANES];
    t_lane             r_sb  [Q_W][LANES];

    for (genvar st = 0; st < Q_W; st++) begin : g_stage
        logic              p_vld;
        logic [DEN_W-1:0]  p_rem [LANES];
        logic [DEN_W-1:0]  p_den [LANES];
        logic [Q_W-1:0]    p_q   [LANES];
        t_lane             p_sb  [LANES];
        logic [DEN_W-1:0]  n_rem [LANES];
        logic [Q_W-1:0]    n_q   [LANES];

        if (st == 0) begin : g_first
            assign p_vld = i_vld;
            assign p_rem = i_rem;
            assign p_den = i_den;
            assign p_sb  = i_sb;
            always_comb begin
                for (int j = 0; j < LANES; j++) p_q[j] = '0;
            end
        end else begin : g_next
            assign p_vld = r_vld[st-1];
            assign p_rem = r_rem[st-1];
            assign p_den = r_den[st-1];
            assign p_q   = r_q[st-1];
            assign p_sb  = r_sb[st-1];
        end

        always_comb begin
            logic [DEN_W+1:0] t;
            for (int j = 0; j < LANES; j++) begin
                t = {1'b0, p_rem[j], 1'b0} - {2'b0, p_den[j]};
                n_rem[j] = t[DEN_W+1] ? {p_rem[j][DEN_W-2:0], 1'b0} : t[DEN_W-1:0];
                n_q[j]   = {p_q[j][Q_W-2:0], ~t[DEN_W+1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[st] <= 1'b0;
            end else if (i_en) begin
                r_vld[st] <= p_vld;
            end
            if (i_en) begin
                r_rem[st] <= n_rem;
                r_den[st] <= p_den;
                r_q[st]   <= n_q;
                r_sb[st]  <= p_sb;
            end
        end
    end

    assign o_vld = r_vld[Q_W-1];
    assign o_q   = r_q[Q_W-1];
    assign o_sb  = r_sb[Q_W-1];
endmodule

[rtl/core/vas_ser.sv]
// Builds the six polygon corners and plays them out as a 12-vertex fan.
`timescale 1ns / 1ps
module vas_ser (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [vas_pkg::Q_W-1:0]  i_q  [vas_pkg::LANES],
    input  vas_pkg::t_lane           i_sb [vas_pkg::LANES],
    output logic                     o_load,
    output logic                     o_vld,
    input  logic                     i_ready,
    output logic [vas_pkg::C_W-1:0]  o_vert_x,
    output logic [vas_pkg::C_W-1:0]  o_vert_y,
    output logic [vas_pkg::C_W-1:0]  o_vert_z,
    output logic [3:0]               o_fan_position,
    output logic                     o_last_vertex
);
    import vas_pkg::*;

    logic [C_W-1:0] n_vert [LANES][3];
    logic [C_W-1:0] r_vert [LANES][3];
    logic [3:0]     r_cnt;
    logic           r_busy;
    logic           last;

    always_comb begin
        logic [C_W-1:0] qc;
        for (int j = 0; j < LANES; j++) begin
            unique case (i_sb[j].cls)
                CLS_DIV:   qc = C_W'(i_q[j]);
                CLS_ABOVE: qc = FIX_ONE;
                default:   qc = '0;
            endcase
            for (int a = 0; a < 3; a++) begin
                if (i_sb[j].axis == 2'(a)) begin
                    n_vert[j][a] = i_sb[j].neg ? FIX_ONE - qc : qc;
                end else begin
                    n_vert[j][a] = CORNER_XYZ[i_sb[j].s][a] ? FIX_ONE : '0;
                end
            end
        end
    end

    assign last   = (r_cnt == 4'(FAN_LEN - 1));
    assign o_load = i_vld && (!r_busy || (i_ready && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy && i_ready) begin
            if (last) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + 4'd1;
            end
        end
        if (o_load) r_vert <= n_vert;
    end

    assign o_vld          = r_busy;
    assign o_vert_x       = r_vert[FAN_ORDER[r_cnt]][0];
    assign o_vert_y       = r_vert[FAN_ORDER[r_cnt]][1];
    assign o_vert_z       = r_vert[FAN_ORDER[r_cnt]][2];
    assign o_fan_position = r_cnt;
    assign o_last_vertex  = last;
endmodule

[rtl/core/view_aligned_volume_slicer_unit.sv]
// View-aligned unit-cube slicer: top level, config registers and stall control.
// Pipeline: 4 front stages, 15 divider stages (one bit each), 1 fan stage.
// Throughput: one item per cycle enters while the pipe is not stalled; a slice that
//   hits the cube emits 12 vertices at one per cycle while the output is ready.
//   Missed or out-of-range slices emit nothing.
// Reset (sync, active low) clears valids, slice_count to 42, range_margin to 16.
`timescale 1ns / 1ps
module view_aligned_volume_slicer_unit #(
    parameter int MAX_SLICES = vas_pkg::MAX_SLICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // dir_x, dir_y, dir_z, slice_index
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // vert_x, vert_y, vert_z, fan_position, 4'b0
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);
    import vas_pkg::*;
    localparam int DEN_W = $clog2(MAX_SLICES+1) + 16;

    logic [SC_W-1:0] r_slice_count;
    logic [RM_W-1:0] r_range_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_count  <= SC_W'(42);
            r_range_margin <= RM_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SLICE_COUNT:  r_slice_count  <= i_cfg_data[SC_W-1:0];
                REG_RANGE_MARGIN: r_range_margin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic              en, load;
    logic              f_vld, d_vld;
    logic [DEN_W-1:0]  f_rem [LANES];
    logic [DEN_W-1:0]  f_den [LANES];
    t_lane             f_sb  [LANES];
    logic [Q_W-1:0]    d_q   [LANES];
    t_lane             d_sb  [LANES];
    logic [C_W-1:0]    vx, vy, vz;
    logic [3:0]        fpos;

    // whole pipe advances unless its last stage holds an item the fan stage can't take
    assign en              = !d_vld || load;
    assign o_s_axis_tready = en;

    vas_front #(.MAX_SLICES(MAX_SLICES)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_vld          (i_s_axis_tvalid),
        .i_dir_x        (i_s_axis_tdata[15:0]),
        .i_dir_y        (i_s_axis_tdata[31:16]),
        .i_dir_z        (i_s_axis_tdata[47:32]),
        .i_slice_index  (i_s_axis_tdata[55:48]),
        .i_slice_count  (r_slice_count),
        .i_range_margin (r_range_margin),
        .o_vld          (f_vld),
        .o_rem          (f_rem),
        .o_den          (f_den),
        .o_sb           (f_sb)
    );

    vas_div #(.MAX_SLICES(MAX_SLICES)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_rem   (f_rem),
        .i_den   (f_den),
        .i_sb    (f_sb),
        .o_vld   (d_vld),
        .o_q     (d_q),
        .o_sb    (d_sb)
    );

    vas_ser u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (d_vld),
        .i_q            (d_q),
        .i_sb           (d_sb),
        .o_load         (load),
        .o_vld          (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_vert_x       (vx),
        .o_vert_y       (vy),
        .o_vert_z       (vz),
        .o_fan_position (fpos),
        .o_last_vertex  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0, fpos, vz, vy, vx};
endmodule
